@@ rtl/core/positional_list_engine_defines.svh @@
// assertion macros for the list engine checkers
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, inactive during reset
`define PLE_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("list engine check failed");

// next-cycle implication, inactive during reset
`define PLE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("list engine check failed");

`endif

@@ rtl/core/ple_pkg.sv @@
// types and constants shared by the list engine modules
package ple_pkg;

	localparam int CAPACITY    = 16;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int POS_W       = 5;
	localparam int VAL_W       = 32;
	localparam int ITEM_POS_W  = 4;
	localparam int LEN_W       = 5;
	localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int DUMP_LIMIT  = (MAX_RESULTS < CAPACITY) ? MAX_RESULTS : CAPACITY;

	typedef enum logic [2:0] {
		REQ_APPEND    = 3'd0,
		REQ_PREPEND   = 3'd1,
		REQ_INSERT_AT = 3'd2,
		REQ_DEL_FIRST = 3'd3,
		REQ_DEL_LAST  = 3'd4,
		REQ_DEL_AT    = 3'd5,
		REQ_DUMP      = 3'd6
	} req_code_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_code_t;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_ROT
	} cell_op_t;

	typedef struct packed {
		logic [2:0]              req_type;
		logic [POS_W-1:0]        position_in;
		logic signed [VAL_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] item_value;
		logic [ITEM_POS_W-1:0]   item_position;
		logic [LEN_W-1:0]        list_length;
		logic [1:0]              status;
		logic                    last;
	} res_t;

	typedef struct packed {
		cell_op_t                op;
		logic [CNT_W-1:0]        pos;
		logic [CNT_W-1:0]        count;
		logic signed [VAL_W-1:0] value;
	} cell_ctl_t;

endpackage

@@ rtl/core/positional_list_engine.sv @@
// Edit operations: status result in the cycle after start, a new transaction each cycle while not busy.
// Dump of n elements: busy while the cell chain rotates once through the list;
// results one per cycle, the first registered after the controller enters the dump state, last flagged.
// Dump of an empty list gives no result and does not raise busy.
// Reset clears the element count and controller; cell contents are not cleared.
// Results cannot be stalled and last exactly one cycle.
module positional_list_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ple_pkg::req_t  req,
	output logic           busy,
	output logic           done,
	output ple_pkg::res_t  res
);

	ple_pkg::cell_ctl_t               ctl;
	logic signed [ple_pkg::VAL_W-1:0] elems [ple_pkg::CAPACITY];

	ple_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.head   (elems[0]),
		.busy   (busy),
		.ctl    (ctl),
		.done   (done),
		.res    (res)
	);

	for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
		logic signed [ple_pkg::VAL_W-1:0] left_v;
		logic signed [ple_pkg::VAL_W-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = elems[i-1];
		end

		if (i == ple_pkg::CAPACITY - 1) begin : g_end
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = elems[i+1];
		end

		ple_cell u_cell (
			.clk   (clk),
			.idx   (ple_pkg::IDX_W'(i)),
			.ctl   (ctl),
			.left  (left_v),
			.right (right_v),
			.head  (elems[0]),
			.elem  (elems[i])
		);
	end

endmodule

@@ rtl/core/ple_cell.sv @@
// one storage cell of the list chain, shifts with its neighbors
module ple_cell (
	input  logic                             clk,
	input  logic [ple_pkg::IDX_W-1:0]        idx,
	input  ple_pkg::cell_ctl_t               ctl,
	input  logic signed [ple_pkg::VAL_W-1:0] left,
	input  logic signed [ple_pkg::VAL_W-1:0] right,
	input  logic signed [ple_pkg::VAL_W-1:0] head,
	output logic signed [ple_pkg::VAL_W-1:0] elem
);

	logic signed [ple_pkg::VAL_W-1:0] elem_q;
	logic [ple_pkg::CNT_W-1:0]        idx_ext;
	logic [ple_pkg::CNT_W-1:0]        idx_nxt;

	assign idx_ext = ple_pkg::CNT_W'(idx);
	assign idx_nxt = idx_ext + ple_pkg::CNT_W'(1);
	assign elem    = elem_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			ple_pkg::CELL_INS: begin
				if (idx_ext > ctl.pos) begin
					elem_q <= left;
				end else if (idx_ext == ctl.pos) begin
					elem_q <= ctl.value;
				end
			end
			ple_pkg::CELL_DEL: begin
				if (idx_ext >= ctl.pos) begin
					elem_q <= right;
				end
			end
			ple_pkg::CELL_ROT: begin
				// the last occupied cell wraps the head around
				if (idx_nxt == ctl.count) begin
					elem_q <= head;
				end else begin
					elem_q <= right;
				end
			end
			default: begin
				elem_q <= elem_q;
			end
		endcase
	end

endmodule

@@ rtl/core/ple_ctrl.sv @@
// request decode, element count, dump sequencing and result register
module ple_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  ple_pkg::req_t                    req,
	input  logic signed [ple_pkg::VAL_W-1:0] head,
	output logic                             busy,
	output ple_pkg::cell_ctl_t               ctl,
	output logic                             done,
	output ple_pkg::res_t                    res
);

	ple_pkg::state_t           state_q, state_d;
	logic [ple_pkg::CNT_W-1:0] count_q, count_d;
	logic [ple_pkg::CNT_W-1:0] dcnt_q;
	logic [ple_pkg::CNT_W-1:0] dcnt_nxt;
	logic [ple_pkg::CNT_W-1:0] dump_n;
	logic [ple_pkg::CMP_W-1:0] pos_ext;
	logic [ple_pkg::CMP_W-1:0] cnt_ext;
	logic                      acc;
	logic                      full;
	logic                      empty;
	logic                      emit;
	logic                      dump_end;
	logic [1:0]                stat;
	logic                      done_q;
	ple_pkg::res_t             res_q;

	assign busy     = (state_q == ple_pkg::S_DUMP);
	assign acc      = start && !busy;
	assign full     = (count_q == ple_pkg::CNT_W'(ple_pkg::CAPACITY));
	assign empty    = (count_q == '0);
	assign pos_ext  = ple_pkg::CMP_W'(req.position_in);
	assign cnt_ext  = ple_pkg::CMP_W'(count_q);
	assign dcnt_nxt = dcnt_q + ple_pkg::CNT_W'(1);
	assign dump_n   = (count_q < ple_pkg::CNT_W'(ple_pkg::DUMP_LIMIT)) ?
		count_q : ple_pkg::CNT_W'(ple_pkg::DUMP_LIMIT);
	assign emit     = busy && (dcnt_q < dump_n);
	assign dump_end = (dcnt_nxt == count_q);
	assign done     = done_q;
	assign res      = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ple_pkg::S_IDLE: begin
				if (acc && (req.req_type == ple_pkg::REQ_DUMP) && !empty) begin
					state_d = ple_pkg::S_DUMP;
				end
			end
			ple_pkg::S_DUMP: begin
				if (dump_end) begin
					state_d = ple_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ple_pkg::S_IDLE;
			end
		endcase
	end

	// cell command, status and new count
	always_comb begin
		ctl.op    = ple_pkg::CELL_HOLD;
		ctl.pos   = '0;
		ctl.count = count_q;
		ctl.value = req.value_in;
		stat      = ple_pkg::STAT_OK;
		count_d   = count_q;
		if (busy) begin
			ctl.op = ple_pkg::CELL_ROT;
		end else if (acc) begin
			case (req.req_type)
				ple_pkg::REQ_APPEND, ple_pkg::REQ_PREPEND, ple_pkg::REQ_INSERT_AT: begin
					if (full) begin
						stat = ple_pkg::STAT_FULL;
					end else begin
						ctl.op  = ple_pkg::CELL_INS;
						count_d = count_q + ple_pkg::CNT_W'(1);
						if (req.req_type == ple_pkg::REQ_APPEND) begin
							ctl.pos = count_q;
						end else if (req.req_type == ple_pkg::REQ_PREPEND) begin
							ctl.pos = '0;
						end else if (pos_ext > cnt_ext) begin
							ctl.pos = count_q;
						end else begin
							ctl.pos = ple_pkg::CNT_W'(req.position_in);
						end
					end
				end
				ple_pkg::REQ_DEL_FIRST, ple_pkg::REQ_DEL_LAST: begin
					if (empty) begin
						stat = ple_pkg::STAT_EMPTY;
					end else begin
						ctl.op  = ple_pkg::CELL_DEL;
						count_d = count_q - ple_pkg::CNT_W'(1);
						ctl.pos = (req.req_type == ple_pkg::REQ_DEL_LAST) ?
							count_q - ple_pkg::CNT_W'(1) : '0;
					end
				end
				ple_pkg::REQ_DEL_AT: begin
					if (empty) begin
						stat = ple_pkg::STAT_EMPTY;
					end else if (pos_ext >= cnt_ext) begin
						stat = ple_pkg::STAT_NOT_FOUND;
					end else begin
						ctl.op  = ple_pkg::CELL_DEL;
						count_d = count_q - ple_pkg::CNT_W'(1);
						ctl.pos = ple_pkg::CNT_W'(req.position_in);
					end
				end
				default: begin
					stat = ple_pkg::STAT_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ple_pkg::S_IDLE;
			count_q <= '0;
			dcnt_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			dcnt_q  <= busy ? dcnt_nxt : '0;
			done_q  <= emit || (acc && (req.req_type != ple_pkg::REQ_DUMP));
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.item_value    <= head;
			res_q.item_position <= ple_pkg::ITEM_POS_W'(dcnt_q);
			res_q.list_length   <= ple_pkg::LEN_W'(count_q);
			res_q.status        <= ple_pkg::STAT_OK;
			res_q.last          <= (dcnt_nxt == dump_n);
		end else if (acc && (req.req_type != ple_pkg::REQ_DUMP)) begin
			res_q.item_value    <= '0;
			res_q.item_position <= '0;
			res_q.list_length   <= ple_pkg::LEN_W'(count_d);
			res_q.status        <= stat;
			res_q.last          <= 1'b1;
		end
	end

endmodule

@@ rtl/core/ple_checker.sv @@
// port-level checks for the list engine, bound to the top level
`include "positional_list_engine_defines.svh"

module ple_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input ple_pkg::req_t req,
	input logic          busy,
	input logic          done,
	input ple_pkg::res_t res
);

	// an edit transaction answers in the next cycle with a single final result
	`PLE_ASSERT_NEXT(a_edit_result, clk, arst_n, start && !busy && (req.req_type != ple_pkg::REQ_DUMP), done && res.last)

	// error results are always final and carry no element
	`PLE_ASSERT_NOW(a_err_final, clk, arst_n, done && (res.status != ple_pkg::STAT_OK), res.last && (res.item_value == '0))

	// dump results come back to back until the last one
	`PLE_ASSERT_NEXT(a_dump_cont, clk, arst_n, done && !res.last, done && (res.status == ple_pkg::STAT_OK))

	// reported length never exceeds the capacity
	`PLE_ASSERT_NOW(a_len_cap, clk, arst_n, done, 32'(res.list_length) <= ple_pkg::CAPACITY)

endmodule

bind positional_list_engine ple_checker u_ple_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.req    (req),
	.busy   (busy),
	.done   (done),
	.res    (res)
);

@@ verif/list_scoreboard_pkg.sv @@
// scoreboard for the list engine: tracks list contents and checks every result
package list_scoreboard_pkg;

	import ple_pkg::*;

	class list_scoreboard;
		logic signed [VAL_W-1:0] contents[$];
		res_t awaited_results[$];
		int requests_taken;
		int results_checked;
		int fail_count;
		int peak_length;
		int dump_entries;
		int status_seen[4];

		function int length();
			return contents.size();
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		function void push_status(logic [1:0] code);
			res_t r;
			r = '0;
			r.list_length = LEN_W'(contents.size());
			r.status = code;
			r.last = 1'b1;
			awaited_results.push_back(r);
			status_seen[code]++;
		endfunction

		function logic [1:0] insert_value(int at, logic signed [VAL_W-1:0] v);
			if (contents.size() >= CAPACITY)
				return STAT_FULL;
			if (at > contents.size())
				at = contents.size();
			contents.insert(at, v);
			if (contents.size() > peak_length)
				peak_length = contents.size();
			return STAT_OK;
		endfunction

		function logic [1:0] remove_value(int at);
			if (contents.size() == 0)
				return STAT_EMPTY;
			if (at >= contents.size())
				return STAT_NOT_FOUND;
			contents.delete(at);
			return STAT_OK;
		endfunction

		// called for every accepted transaction, queues the results it must cause
		function void apply_request(req_t r);
			int n;
			res_t d;
			logic [1:0] code;
			requests_taken++;
			code = STAT_OK;
			case (r.req_type)
				REQ_APPEND:    code = insert_value(contents.size(), r.value_in);
				REQ_PREPEND:   code = insert_value(0, r.value_in);
				REQ_INSERT_AT: code = insert_value(int'(r.position_in), r.value_in);
				REQ_DEL_FIRST: code = remove_value(0);
				REQ_DEL_LAST:  code = remove_value(contents.size() - 1);
				REQ_DEL_AT:    code = remove_value(int'(r.position_in));
				REQ_DUMP: begin
					n = (contents.size() > MAX_RESULTS) ? MAX_RESULTS : contents.size();
					for (int i = 0; i < n; i++) begin
						d = '0;
						d.item_value = contents[i];
						d.item_position = ITEM_POS_W'(i);
						d.list_length = LEN_W'(contents.size());
						d.status = STAT_OK;
						d.last = (i == n - 1);
						awaited_results.push_back(d);
						dump_entries++;
					end
					return;
				end
				default: code = STAT_OK;
			endcase
			push_status(code);
		endfunction

		function void check_result(res_t got);
			res_t want;
			results_checked++;
			if (awaited_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: value %0d pos %0d len %0d status %0d last %0d",
						got.item_value, got.item_position, got.list_length, got.status, got.last);
				return;
			end
			want = awaited_results.pop_front();
			if (got.item_value !== want.item_value || got.item_position !== want.item_position ||
				got.list_length !== want.list_length || got.status !== want.status ||
				got.last !== want.last) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("mismatch: expected value %0d pos %0d len %0d status %0d last %0d",
						want.item_value, want.item_position, want.list_length, want.status,
						want.last);
					$display("          got      value %0d pos %0d len %0d status %0d last %0d",
						got.item_value, got.item_position, got.list_length, got.status, got.last);
				end
			end
		endfunction
	endclass

endpackage

@@ verif/positional_list_engine_test.sv @@
// top of the list engine test: clock, reset, request driver and result monitor
module positional_list_engine_test;

	import ple_pkg::*;
	import list_scoreboard_pkg::*;

	localparam logic [2:0] REQ_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS = 415;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int BIAS_GROW = 0;
	localparam int BIAS_SHRINK = 1;
	localparam int BIAS_MIXED = 2;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	res_t res;

	list_scoreboard sb;
	int quiet_cycles = 0;

	req_code_t grow_ops[3] = '{REQ_APPEND, REQ_PREPEND, REQ_INSERT_AT};
	req_code_t shrink_ops[3] = '{REQ_DEL_FIRST, REQ_DEL_LAST, REQ_DEL_AT};

	positional_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.res(res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.apply_request(req);
			if (done)
				sb.check_result(res);
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic req_t make_req(logic [2:0] op, logic [POS_W-1:0] pos,
		logic [VAL_W-1:0] v);
		req_t r;
		r.req_type = op;
		r.position_in = pos;
		r.value_in = v;
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t pick_request(int bias, int len);
		req_t r;
		int roll;
		int grow_pct;
		int shrink_pct;
		roll = $urandom_range(99);
		grow_pct = (bias == BIAS_GROW) ? 70 : (bias == BIAS_SHRINK) ? 25 : 45;
		shrink_pct = (bias == BIAS_GROW) ? 20 : (bias == BIAS_SHRINK) ? 63 : 43;
		r.value_in = pick_value();
		// mostly positions near the current length, sometimes anywhere in the field
		if ($urandom_range(7) == 0)
			r.position_in = POS_W'($urandom);
		else
			r.position_in = POS_W'($urandom_range(len + 1));
		if (roll < grow_pct)
			r.req_type = grow_ops[$urandom_range(2)];
		else if (roll < grow_pct + shrink_pct)
			r.req_type = shrink_ops[$urandom_range(2)];
		else if (roll < 97)
			r.req_type = REQ_DUMP;
		else
			r.req_type = REQ_UNUSED;
		return r;
	endfunction

	task automatic send(req_t r);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// start low with junk on the request bus
	task automatic idle(int cycles);
		for (int i = 0; i < cycles; i++) begin
			start <= 1'b0;
			req <= make_req(3'($urandom), POS_W'($urandom), $urandom);
			@(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int sent;
		int bias;
		int phase_left;
		int burst;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: dump gives nothing, every delete flavor reports empty
		send(make_req(REQ_DUMP, 5'd0, '0));
		send(make_req(REQ_DEL_FIRST, 5'd0, '0));
		send(make_req(REQ_DEL_LAST, 5'd0, '0));
		send(make_req(REQ_DEL_AT, 5'd31, '0));
		send(make_req(REQ_DEL_AT, 5'd0, '0));
		send(make_req(REQ_APPEND, 5'd0, 32'h7fff_ffff));
		send(make_req(REQ_PREPEND, 5'd0, 32'h8000_0000));
		send(make_req(REQ_INSERT_AT, 5'd1, '0));
		// index past the end appends
		send(make_req(REQ_INSERT_AT, 5'd31, '1));
		send(make_req(REQ_INSERT_AT, 5'd0, 32'h5555_5555));
		send(make_req(REQ_DUMP, 5'd0, '0));
		send(make_req(REQ_DEL_AT, 5'd5, '0));
		send(make_req(REQ_DEL_AT, 5'd16, '0));
		send(make_req(REQ_DEL_AT, 5'd2, '0));
		send(make_req(REQ_DEL_LAST, 5'd0, '0));
		send(make_req(REQ_DEL_FIRST, 5'd0, '0));
		send(make_req(REQ_UNUSED, 5'd10, 32'h1234_5678));
		send(make_req(REQ_DUMP, 5'd0, '0));
		settle();

		sent = 0;
		bias = BIAS_GROW;
		phase_left = 60;
		while (sent < RANDOM_ITEMS) begin
			if (phase_left <= 0) begin
				bias = $urandom_range(2);
				phase_left = $urandom_range(20, 60);
			end
			burst = ($urandom_range(4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
			for (int i = 0; i < burst; i++) begin
				send(pick_request(bias, sb.length()));
				sent++;
				phase_left--;
			end
			if ($urandom_range(7) == 0)
				settle();
			else
				idle($urandom_range(1, 6));
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d transactions, %0d results checked, %0d dump entries, peak length %0d",
			sb.requests_taken, sb.results_checked, sb.dump_entries, sb.peak_length);
		$display("status results: %0d ok, %0d full drops, %0d empty deletes, %0d bad indexes",
			sb.status_seen[STAT_OK], sb.status_seen[STAT_FULL], sb.status_seen[STAT_EMPTY],
			sb.status_seen[STAT_NOT_FOUND]);
		if (sb.pending() != 0)
			$display("%0d expected results never arrived", sb.pending());
		if (sb.fail_count > 10)
			$display("%0d mismatches in total", sb.fail_count);
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ positional_list_engine.f @@
+incdir+rtl/core
rtl/core/ple_pkg.sv
rtl/core/ple_cell.sv
rtl/core/ple_ctrl.sv
rtl/core/positional_list_engine.sv
rtl/core/ple_checker.sv
verif/list_scoreboard_pkg.sv
verif/positional_list_engine_test.sv
